// ===== hdl/lcte_pkg.sv =====
`default_nettype none

package lcte_pkg;

  // Default number of cells in the chain.
  localparam int CapacityDef = 16;

  localparam int DataW = 32;
  localparam int ExpW  = 33;
  localparam int CapW  = 5;
  localparam int CfgIdxW = 1;

  localparam logic [CapW-1:0]  CapReset = 5'd16;
  localparam logic [DataW-1:0] TtlReset = 32'd5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegCapacity = 1'b0;
  localparam logic [CfgIdxW-1:0] RegTtl      = 1'b1;

  // Operation codes carried by the action field of a word.
  localparam logic ActGet = 1'b0;
  localparam logic ActPut = 1'b1;

  // Operation every cell performs in a given cycle.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_EXPIRE,
    OP_PACK,
    OP_SHIFT
  } cell_op_e;

  // Contents of one cell.
  typedef struct packed {
    logic              valid;
    logic [DataW-1:0]  key;
    logic [DataW-1:0]  value;
    logic [ExpW-1:0]   expiry;
  } entry_t;

  // Per-cell control word from the sequencer.
  typedef struct packed {
    cell_op_e          op;
    logic [DataW-1:0]  now;
    logic [DataW-1:0]  key;
    logic              take_prev;
    logic              allow;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/lcte_cell.sv =====
`default_nettype none

// One entry of the recency-ordered chain. Lower positions are more recent.
module lcte_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lcte_pkg::cell_ctl_t ctl_i,
  input  wire lcte_pkg::entry_t  prev_i,
  input  wire lcte_pkg::entry_t  next_i,
  output lcte_pkg::entry_t       entry_o,
  output logic                   match_o
);

  logic                         valid_q, valid_d;
  logic [lcte_pkg::DataW-1:0]   key_q, key_d;
  logic [lcte_pkg::DataW-1:0]   value_q, value_d;
  logic [lcte_pkg::ExpW-1:0]    expiry_q, expiry_d;

  always_comb begin
    valid_d  = valid_q;
    key_d    = key_q;
    value_d  = value_q;
    expiry_d = expiry_q;
    case (ctl_i.op)
      lcte_pkg::OP_EXPIRE: begin
        if (valid_q && (expiry_q <= {1'b0, ctl_i.now})) begin
          valid_d = 1'b0;
        end
      end
      lcte_pkg::OP_PACK: begin
        // A live neighbor behind a hole moves up; its old place becomes the hole.
        if (!valid_q && next_i.valid) begin
          valid_d  = 1'b1;
          key_d    = next_i.key;
          value_d  = next_i.value;
          expiry_d = next_i.expiry;
        end else if (valid_q && !prev_i.valid) begin
          valid_d = 1'b0;
        end
      end
      lcte_pkg::OP_SHIFT: begin
        if (ctl_i.take_prev) begin
          valid_d  = prev_i.valid && ctl_i.allow;
          key_d    = prev_i.key;
          value_d  = prev_i.value;
          expiry_d = prev_i.expiry;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    value_q  <= value_d;
    expiry_q <= expiry_d;
  end

  assign entry_o = '{valid: valid_q, key: key_q, value: value_q, expiry: expiry_q};
  assign match_o = valid_q && (key_q == ctl_i.key);

endmodule

`default_nettype wire

// ===== hdl/lru_cache_with_ttl_expiry_unit.sv =====
`default_nettype none

// Fully associative key/value cache with least-recently-used replacement and
// a time-to-live, built as a chain of CAPACITY cells kept in recency order
// (cell 0 is the most recent entry). A word is accepted when start is high
// and busy is low; exactly one result word follows, shown on hit_o and
// read_value_o for a single cycle while done_o is high. The receiver cannot
// stall, so the result must be captured in that cycle. Each word passes
// through these steps in order: a step that drops expired entries; packing,
// in which every live cell directly behind a hole moves one place up per
// cycle until no hole is left in front of a live entry; the parallel key
// compare; the chain shift that moves the hit or new entry to the front;
// and then the result cycle, in which the next word may already be
// accepted. A get that hits returns the stored value; every other word
// returns -1, with hit_o telling whether the key was live. The
// configuration port (capacity_in_use at index 0, time_to_live at index 1)
// may only be written while busy is low. Valid marks clear at reset; no
// clearing pass is needed.
module lru_cache_with_ttl_expiry_unit #(
  parameter int CAPACITY = lcte_pkg::CapacityDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                action_i,
  input  wire logic signed [lcte_pkg::DataW-1:0]   lookup_key_i,
  input  wire logic signed [lcte_pkg::DataW-1:0]   write_value_i,
  input  wire logic        [lcte_pkg::DataW-1:0]   current_time_i,
  output logic                                     done_o,
  output logic                                     hit_o,
  output logic signed [lcte_pkg::DataW-1:0]        read_value_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [lcte_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [lcte_pkg::DataW-1:0]          cfg_wdata_i
);

  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW = $clog2(CAPACITY + 1);
  // Common width for comparing the capacity register against cell positions.
  localparam int MixW = (CntW > lcte_pkg::CapW) ? CntW : lcte_pkg::CapW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPIRE,
    ST_PACK,
    ST_LOOKUP,
    ST_UPDATE
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [lcte_pkg::CapW-1:0]  cap_q;
  logic [lcte_pkg::DataW-1:0] ttl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lcte_pkg::CapReset;
      ttl_q <= lcte_pkg::TtlReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lcte_pkg::RegCapacity: cap_q <= cfg_wdata_i[lcte_pkg::CapW-1:0];
        lcte_pkg::RegTtl:      ttl_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Zero acts as one, anything above the chain length as the chain length.
  logic [MixW-1:0] cap_eff;
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = MixW'(1);
    end else if (MixW'(cap_q) > MixW'(CAPACITY)) begin
      cap_eff = MixW'(CAPACITY);
    end else begin
      cap_eff = MixW'(cap_q);
    end
  end

  // Word being served.
  logic                       act_q;
  logic [lcte_pkg::DataW-1:0] key_q;
  logic [lcte_pkg::DataW-1:0] wval_q;
  logic [lcte_pkg::DataW-1:0] now_q;

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      act_q  <= action_i;
      key_q  <= lookup_key_i;
      wval_q <= write_value_i;
      now_q  <= current_time_i;
    end
  end

  logic is_put;
  assign is_put = (act_q == lcte_pkg::ActPut);

  // Lookup results, captured in the compare cycle.
  logic                       lk_hit_q;
  logic [IdxW-1:0]            lk_idx_q;
  logic [lcte_pkg::DataW-1:0] lk_val_q;
  logic [lcte_pkg::ExpW-1:0]  lk_exp_q;

  // The chain.
  lcte_pkg::entry_t    entries [CAPACITY];
  lcte_pkg::cell_ctl_t ctls    [CAPACITY];
  logic [CAPACITY-1:0] match;
  lcte_pkg::entry_t    head;
  lcte_pkg::entry_t    empty_entry;

  logic [lcte_pkg::ExpW-1:0] exp_new;
  assign exp_new = {1'b0, now_q} + {1'b0, ttl_q};

  assign empty_entry = '{valid: 1'b0, key: '0, value: '0, expiry: '0};

  // Word entering cell 0 on a shift: the hit entry or the new entry.
  assign head = '{valid: 1'b1,
                  key: key_q,
                  value: is_put ? wval_q : lk_val_q,
                  expiry: is_put ? exp_new : lk_exp_q};

  logic do_shift;
  logic limit_on;
  logic [IdxW-1:0] bound;
  lcte_pkg::cell_op_e op;

  assign do_shift = lk_hit_q || is_put;
  // A put that misses shifts the whole chain and trims it to the capacity.
  assign limit_on = !lk_hit_q;
  assign bound    = lk_hit_q ? lk_idx_q : IdxW'(CAPACITY - 1);

  always_comb begin
    case (state_q)
      ST_EXPIRE: op = lcte_pkg::OP_EXPIRE;
      ST_PACK:   op = lcte_pkg::OP_PACK;
      ST_UPDATE: op = do_shift ? lcte_pkg::OP_SHIFT : lcte_pkg::OP_HOLD;
      default:   op = lcte_pkg::OP_HOLD;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lcte_pkg::entry_t prev_e;
    lcte_pkg::entry_t next_e;

    if (i == 0) begin : g_first
      assign prev_e = head;
    end else begin : g_mid
      assign prev_e = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_e = empty_entry;
    end else begin : g_inner
      assign next_e = entries[i+1];
    end

    assign ctls[i] = '{op: op,
                       now: now_q,
                       key: key_q,
                       take_prev: (IdxW'(i) <= bound),
                       allow: !limit_on || (MixW'(i) < cap_eff)};

    lcte_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctls[i]),
      .prev_i  (prev_e),
      .next_i  (next_e),
      .entry_o (entries[i]),
      .match_o (match[i])
    );
  end

  // A hole in front of a live entry means the chain is not packed yet.
  logic gap;
  always_comb begin
    gap = 1'b0;
    for (int i = 0; i < CAPACITY - 1; i++) begin
      gap = gap | (!entries[i].valid && entries[i+1].valid);
    end
  end

  // Live keys are unique, so at most one cell matches and an OR selects it.
  logic                       hit_c;
  logic [IdxW-1:0]            idx_c;
  logic [lcte_pkg::DataW-1:0] val_c;
  logic [lcte_pkg::ExpW-1:0]  exp_c;
  always_comb begin
    hit_c = 1'b0;
    idx_c = '0;
    val_c = '0;
    exp_c = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        hit_c = 1'b1;
        idx_c = idx_c | IdxW'(i);
        val_c = val_c | entries[i].value;
        exp_c = exp_c | entries[i].expiry;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOOKUP) begin
      lk_hit_q <= hit_c;
      lk_idx_q <= idx_c;
      lk_val_q <= val_c;
      lk_exp_q <= exp_c;
    end
  end

  // Sequencer and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      done_o       <= 1'b0;
      hit_o        <= 1'b0;
      read_value_o <= '0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_EXPIRE;
          end
        end
        ST_EXPIRE: begin
          state_q <= ST_PACK;
        end
        ST_PACK: begin
          if (!gap) begin
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          state_q <= ST_UPDATE;
        end
        ST_UPDATE: begin
          done_o       <= 1'b1;
          hit_o        <= lk_hit_q;
          read_value_o <= (!is_put && lk_hit_q) ? lk_val_q : '1;
          state_q      <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy = (state_q != ST_IDLE);

  // Between words the live entries always sit packed at the front.
  a_packed_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !gap)
    else $error("live entries not packed while idle");

  // An accepted word always starts the sequence.
  a_start_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == ST_EXPIRE))
    else $error("accepted word did not start the sequence");

  // A result is only produced after the update cycle, and for one cycle.
  a_done_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == ST_UPDATE) && !busy)
    else $error("result strobe outside the result cycle");

  // Only a get that hits returns something other than -1.
  a_value_on_get_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (!hit_o || is_put)) |-> (read_value_o == '1))
    else $error("read value returned without a get hit");

  // At most one cell holds a given live key.
  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) |-> $onehot0(match))
    else $error("duplicate live key in the chain");

endmodule

`default_nettype wire
